[rtl/core/mbss_pkg.sv]
// Shared constants, register codes and the configuration bundle of the signature scanner.
`timescale 1ns / 1ps
`default_nettype none

package mbss_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int LANES        = 16;
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int OUT_OFFSET_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_MASK_LOW       = 3'd2,
    CFG_MASK_HIGH      = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4
  } mbss_cfg_idx_t;

  // Pattern and mask lanes, lane 0 in the low byte; length already clamped.
  typedef struct packed {
    logic [LANES-1:0][BYTE_W-1:0] pattern;
    logic [LANES-1:0][BYTE_W-1:0] mask;
    logic [LEN_W-1:0]             length;
  } mbss_cfg_t;

endpackage

`default_nettype wire

[rtl/core/mbss_if.sv]
// Valid/ready channel interfaces for the byte stream, the results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface mbss_in_if
  import mbss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbss_out_if
  import mbss_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [OUT_OFFSET_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface mbss_cfg_if
  import mbss_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/mbss_cfg_regs.sv]
// Configuration register file with pattern length clamping.
`timescale 1ns / 1ps
`default_nettype none

module mbss_cfg_regs
  import mbss_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mbss_cfg_if.sink    cfg,
  output mbss_cfg_t   cfg_o
);

  logic [CFG_DATA_W-1:0] pat_lo_r, pat_lo_nxt;
  logic [CFG_DATA_W-1:0] pat_hi_r, pat_hi_nxt;
  logic [CFG_DATA_W-1:0] msk_lo_r, msk_lo_nxt;
  logic [CFG_DATA_W-1:0] msk_hi_r, msk_hi_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      len_act;

  assign cfg.ready = rst_n;

  always_comb begin
    pat_lo_nxt = pat_lo_r;
    pat_hi_nxt = pat_hi_r;
    msk_lo_nxt = msk_lo_r;
    msk_hi_nxt = msk_hi_r;
    len_nxt    = len_r;
    if (cfg.valid && cfg.ready) begin
      unique case (mbss_cfg_idx_t'(cfg.index))
        CFG_PATTERN_LOW:    pat_lo_nxt = cfg.data;
        CFG_PATTERN_HIGH:   pat_hi_nxt = cfg.data;
        CFG_MASK_LOW:       msk_lo_nxt = cfg.data;
        CFG_MASK_HIGH:      msk_hi_nxt = cfg.data;
        CFG_PATTERN_LENGTH: len_nxt    = cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      msk_lo_r <= '0;
      msk_hi_r <= '0;
      len_r    <= LEN_W'(1);
    end else begin
      pat_lo_r <= pat_lo_nxt;
      pat_hi_r <= pat_hi_nxt;
      msk_lo_r <= msk_lo_nxt;
      msk_hi_r <= msk_hi_nxt;
      len_r    <= len_nxt;
    end
  end

  // Zero reads as one byte; anything past the window depth is cut back to it.
  always_comb begin
    len_act = len_r;
    if (len_r == '0) begin
      len_act = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      len_act = LEN_W'(MAX_PATTERN);
    end
  end

  assign cfg_o.pattern = {pat_hi_r, pat_lo_r};
  assign cfg_o.mask    = {msk_hi_r, msk_lo_r};
  assign cfg_o.length  = len_act;

endmodule

`default_nettype wire

[rtl/core/mbss_scan.sv]
// Byte window, region counter and the parallel masked compare of all pattern lanes.
`timescale 1ns / 1ps
`default_nettype none

module mbss_scan
  import mbss_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mbss_cfg_t               cfg_i,
  input  wire logic                    item_valid,
  input  wire logic [BYTE_W-1:0]       data_byte,
  input  wire logic                    last_byte,
  input  wire logic                    advance,
  output      logic                    gen,
  output      logic                    found,
  output      logic [OUT_OFFSET_W-1:0] match_offset
);

  localparam int WIN_IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [BYTE_W-1:0]      win_r     [MAX_PATTERN];
  logic [BYTE_W-1:0]      win_shift [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] count_r, count_nxt;
  logic                   done_r, done_nxt;
  logic [OFFSET_BITS-1:0] pos1;
  logic [OFFSET_BITS-1:0] len_ext;
  logic [LANES-1:0]       lane_ok;
  logic [LEN_W-1:0]       idx;
  logic                   active;
  logic                   hit;

  always_comb begin
    win_shift[0] = data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_shift[k] = win_r[k-1];
    end
  end

  assign active  = !done_r && !(&count_r);
  assign pos1    = count_r + OFFSET_BITS'(1);
  assign len_ext = OFFSET_BITS'(cfg_i.length);

  // Lane j holds the window byte that sits j places after the window start.
  always_comb begin
    idx = '0;
    for (int j = 0; j < LANES; j++) begin
      lane_ok[j] = 1'b1;
      if (j < MAX_PATTERN) begin
        if (LEN_W'(j) < cfg_i.length) begin
          idx        = cfg_i.length - LEN_W'(1) - LEN_W'(j);
          lane_ok[j] = (win_shift[idx[WIN_IW-1:0]] & cfg_i.mask[j]) == cfg_i.pattern[j];
        end
      end
    end
  end

  assign hit          = active && (pos1 >= len_ext) && (&lane_ok);
  assign gen          = item_valid && (hit || (last_byte && !done_r));
  assign found        = hit;
  assign match_offset = hit ? OUT_OFFSET_W'(pos1 - len_ext) : '0;

  always_comb begin
    count_nxt = count_r;
    done_nxt  = done_r;
    if (advance) begin
      if (last_byte) begin
        count_nxt = '0;
        done_nxt  = 1'b0;
      end else if (active) begin
        count_nxt = pos1;
        done_nxt  = hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      done_r  <= done_nxt;
      if (advance) begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
          if (last_byte) begin
            win_r[k] <= '0;
          end else if (active) begin
            win_r[k] <= win_shift[k];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/masked_byte_signature_scan.sv]
// Top level of the masked byte signature scanner: request staging, scan core and result register.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------
//  in_req   | in  | valid / ready  | data_byte[7:0], last_byte
//  out_res  | out | valid / ready  | found, match_offset[31:0]
//  cfg_wr   | in  | valid / ready  | index[2:0], data[63:0]
//
//  One request per cycle sustained unless a result stalls. A request sits in
//  the staging register, is compared against every pattern lane at once, and
//  its result (if any) lands in the result register.
//  Reset (rst_n low, synchronous) clears the registers to their defaults and
//  empties the region; no clearing pass follows.
//  A stalled result holds the result register; the staging register still
//  drains requests that give no result, and in_req stalls only behind a
//  request that does.
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_signature_scan
  import mbss_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mbss_in_if.sink    in_req,
  mbss_out_if.source out_res,
  mbss_cfg_if.sink   cfg_wr
);

  mbss_cfg_t               cfg;

  // Staging register for one request
  logic                    s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0]       s1_data_r;
  logic                    s1_last_r;

  // Result register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r;
  logic [OUT_OFFSET_W-1:0] out_offset_r;

  logic                    gen;
  logic                    hit_found;
  logic [OUT_OFFSET_W-1:0] hit_offset;
  logic                    out_free;
  logic                    advance;
  logic                    in_take;

  mbss_cfg_regs #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .cfg_o (cfg)
  );

  mbss_scan #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .item_valid   (s1_valid_r),
    .data_byte    (s1_data_r),
    .last_byte    (s1_last_r),
    .advance      (advance),
    .gen          (gen),
    .found        (hit_found),
    .match_offset (hit_offset)
  );

  // Advance the staged request when its result has somewhere to go,
  // or at once when it gives no result at all.
  assign out_free = !out_valid_r || out_res.ready;
  assign advance  = s1_valid_r && (!gen || out_free);

  assign in_req.ready = rst_n && (!s1_valid_r || advance);
  assign in_take      = in_req.valid && in_req.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end
  end

  // Hold a waiting result until taken; load a fresh one over it on the same edge.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && gen) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_req.data_byte;
      s1_last_r <= in_req.last_byte;
    end
    if (advance && gen) begin
      out_found_r  <= hit_found;
      out_offset_r <= hit_offset;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.found        = out_found_r;
  assign out_res.match_offset = out_offset_r;

endmodule

`default_nettype wire

[rtl/core/mbss_checker.sv]
// Port-level checks for the signature scanner and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mbss_checker
  import mbss_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic                    out_found,
  input wire logic [OUT_OFFSET_W-1:0] out_offset
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An unmatched region reports offset zero.
  a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_offset == '0)
    else $error("non-zero offset on a miss");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_offset))
    else $error("result changed under stall");

  // A result that appears on an empty output comes from a request that passed the staging register unstalled.
  a_two_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a request two cycles earlier");

endmodule

bind masked_byte_signature_scan mbss_checker u_mbss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_found  (out_res.found),
  .out_offset (out_res.match_offset)
);

`default_nettype wire

[verif/tb.sv]
// Self-checking bench for the signature scanner: planted and noisy regions against a predictor.
`timescale 1ns / 1ps

module tb
  import mbss_pkg::*;
();

  typedef struct {
    logic        found;
    logic [31:0] match_offset;
  } scan_result_t;

  // Tracks the scanner's registers and region state, and queues the result
  // each accepted request should produce.
  class signature_scoreboard;
    logic [7:0]   pattern_lane[LANES];
    logic [7:0]   mask_lane[LANES];
    logic [4:0]   length_code;
    logic [7:0]   window[LANES];      // entry 0 holds the newest byte
    logic [31:0]  region_count;       // saturating byte count in the region
    bit           reported;           // a match was already given this region
    scan_result_t expected_results[$];
    int unsigned  error_count;
    int unsigned  requests_noted;     // every request taken by the scanner

    function new();
      foreach (pattern_lane[i]) begin
        pattern_lane[i] = 8'h00;
        mask_lane[i]    = 8'h00;
      end
      length_code    = 5'd1;
      error_count    = 0;
      requests_noted = 0;
      clear_region();
    endfunction

    function void clear_region();
      foreach (window[i]) window[i] = 8'h00;
      region_count = 32'd0;
      reported     = 1'b0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [63:0] value);
      case (mbss_cfg_idx_t'(index))
        CFG_PATTERN_LOW:    for (int i = 0; i < 8; i++) pattern_lane[i]     = value[8*i +: 8];
        CFG_PATTERN_HIGH:   for (int i = 0; i < 8; i++) pattern_lane[i + 8] = value[8*i +: 8];
        CFG_MASK_LOW:       for (int i = 0; i < 8; i++) mask_lane[i]        = value[8*i +: 8];
        CFG_MASK_HIGH:      for (int i = 0; i < 8; i++) mask_lane[i + 8]    = value[8*i +: 8];
        CFG_PATTERN_LENGTH: length_code = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [7:0] data_byte, logic last_byte);
      int span;
      bit hit;
      requests_noted++;
      if (!reported && region_count != 32'hFFFF_FFFF) begin
        // length zero behaves as one, anything above the lane count as the lane count
        span = (length_code == 0) ? 1 : ((length_code > LANES) ? LANES : int'(length_code));
        for (int i = LANES - 1; i > 0; i--) window[i] = window[i - 1];
        window[0] = data_byte;
        region_count++;
        hit = (region_count >= span);
        for (int j = 0; j < span; j++)
          if ((window[span - 1 - j] & mask_lane[j]) != pattern_lane[j]) hit = 1'b0;
        if (hit) begin
          reported = 1'b1;
          expected_results.push_back('{1'b1, region_count - span});
        end
      end
      if (last_byte) begin
        if (!reported) expected_results.push_back('{1'b0, 32'd0});
        clear_region();
      end
    endfunction

    function void check_result(logic found, logic [31:0] match_offset);
      scan_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: found %0b, match_offset %0d", found, match_offset);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, found);
        error_count++;
      end
      if (match_offset !== want.match_offset) begin
        $error("match_offset: expected %0d, actual %0d", want.match_offset, match_offset);
        error_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mbss_in_if  in_req_if ();
  mbss_out_if out_res_if ();
  mbss_cfg_if cfg_wr_if ();

  masked_byte_signature_scan dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req_if),
    .out_res (out_res_if),
    .cfg_wr  (cfg_wr_if)
  );

  signature_scoreboard scoreboard = new();

  // Percentage of cycles in which each side holds off.
  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 62;

  // Signature currently loaded by the random part, kept for planting.
  logic [7:0] sig_pattern[LANES];
  logic [7:0] sig_mask[LANES];
  int         sig_span;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("masked_byte_signature_scan test failed");
    $finish;
  end

  // Result receiver: drop ready at random according to the current phase.
  initial begin
    out_res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watch all three channels at every edge. Results are checked before the
  // request of the same edge is noted; a request can never produce a result
  // in the cycle it is taken.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_res_if.valid === 1'b1 && out_res_if.ready === 1'b1)
        scoreboard.check_result(out_res_if.found, out_res_if.match_offset);
      if (cfg_wr_if.valid === 1'b1 && cfg_wr_if.ready === 1'b1)
        scoreboard.write_register(cfg_wr_if.index, cfg_wr_if.data);
      if (in_req_if.valid === 1'b1 && in_req_if.ready === 1'b1)
        scoreboard.note_request(in_req_if.data_byte, in_req_if.last_byte);
    end
  end

  // Offer one request, after a random hold-off, and wait until it is taken.
  // Valid is left high so that back-to-back requests stay back to back.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_req_if.valid     <= 1'b1;
    in_req_if.data_byte <= value;
    in_req_if.last_byte <= is_last;
    do @(posedge clk); while (in_req_if.ready !== 1'b1);
  endtask

  // Stop sending and let every outstanding result drain. A request after a
  // match gives no result but may still sit in the two-stage pipe, so wait
  // on before touching the registers.
  task automatic settle_block();
    in_req_if.valid <= 1'b0;
    @(posedge clk);
    while (scoreboard.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Valid stays high between writes; the caller lowers it after the batch.
  task automatic write_register(input mbss_cfg_idx_t index, input logic [63:0] value);
    cfg_wr_if.valid <= 1'b1;
    cfg_wr_if.index <= index;
    cfg_wr_if.data  <= value;
    do @(posedge clk); while (cfg_wr_if.ready !== 1'b1);
  endtask

  task automatic load_registers(input logic [63:0] pat_lo, input logic [63:0] pat_hi,
                                input logic [63:0] msk_lo, input logic [63:0] msk_hi,
                                input logic [63:0] len_word);
    settle_block();
    write_register(CFG_PATTERN_LOW, pat_lo);
    write_register(CFG_PATTERN_HIGH, pat_hi);
    write_register(CFG_MASK_LOW, msk_lo);
    write_register(CFG_MASK_HIGH, msk_hi);
    write_register(CFG_PATTERN_LENGTH, len_word);
    cfg_wr_if.valid <= 1'b0;
  endtask

  function automatic logic [63:0] pack_lanes(input logic [7:0] lanes[LANES], input int base);
    logic [63:0] word;
    for (int i = 0; i < 8; i++) word[8*i +: 8] = lanes[base + i];
    return word;
  endfunction

  // Draw a fresh signature: mostly exact lanes, some partial masks and
  // wildcards, now and then a pattern bit outside its mask, and the
  // out-of-range length codes that the scanner must clamp.
  task automatic apply_random_signature();
    int          roll;
    int          len_roll;
    logic [4:0]  code;
    logic [63:0] len_word;
    roll     = $urandom_range(99);
    len_roll = $urandom_range(99);
    if (len_roll < 8)       code = 5'd0;
    else if (len_roll < 16) code = 5'($urandom_range(31, 17));
    else                    code = 5'($urandom_range(16, 1));
    sig_span = (code == 0) ? 1 : ((code > LANES) ? LANES : int'(code));
    for (int i = 0; i < LANES; i++) begin
      if (roll < 5) begin
        sig_mask[i]    = 8'hFF;
        sig_pattern[i] = 8'hFF;
      end else if (roll < 10) begin
        sig_mask[i]    = 8'h00;
        sig_pattern[i] = 8'h00;
      end else begin
        case ($urandom_range(3))
          0, 1:    sig_mask[i] = 8'hFF;
          2:       sig_mask[i] = 8'($urandom);
          default: sig_mask[i] = 8'h00;
        endcase
        sig_pattern[i] = 8'($urandom) & sig_mask[i];
        // a stray pattern bit outside the mask makes the lane unmatchable
        if ($urandom_range(99) < 3) sig_pattern[i] = sig_pattern[i] | ~sig_mask[i];
      end
    end
    len_word      = {$urandom, $urandom};
    len_word[4:0] = code;
    load_registers(pack_lanes(sig_pattern, 0), pack_lanes(sig_pattern, 8),
                   pack_lanes(sig_mask, 0), pack_lanes(sig_mask, 8), len_word);
  endtask

  // One region: mostly a planted signature at a random place with random
  // don't-care bits, some with one masked bit flipped, the rest pure noise.
  // Most regions are short; a few are long.
  task automatic play_region();
    logic [7:0] region_bytes[$];
    int         roll;
    int         size;
    int         start;
    int         lane;
    int         bit_pos;
    roll = $urandom_range(99);
    size = ($urandom_range(9) == 0) ? $urandom_range(300, 41) : $urandom_range(40, 1);
    for (int i = 0; i < size; i++) region_bytes.push_back(8'($urandom));
    if (roll < 85) begin
      while (region_bytes.size() < sig_span) region_bytes.push_back(8'($urandom));
      start = $urandom_range(region_bytes.size() - sig_span, 0);
      for (int j = 0; j < sig_span; j++)
        region_bytes[start + j] = sig_pattern[j] | (8'($urandom) & ~sig_mask[j]);
      if (roll >= 70) begin
        lane = $urandom_range(sig_span - 1, 0);
        if (sig_mask[lane] != 8'h00) begin
          do bit_pos = $urandom_range(7); while (!sig_mask[lane][bit_pos]);
          region_bytes[start + lane] = region_bytes[start + lane] ^ (8'h01 << bit_pos);
        end
      end
    end
    foreach (region_bytes[i]) send_byte(region_bytes[i], i == region_bytes.size() - 1);
  endtask

  initial begin
    int phase_goal;
    in_req_if.valid     <= 1'b0;
    in_req_if.data_byte <= 8'h00;
    in_req_if.last_byte <= 1'b0;
    cfg_wr_if.valid     <= 1'b0;
    cfg_wr_if.index     <= CFG_PATTERN_LOW;
    cfg_wr_if.data      <= 64'd0;
    rst_n               <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: zero pattern and mask with length one match any byte
    // at offset 0; the closing request follows the match and gives nothing.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // All ones everywhere and length code 31, clamped to the full 16 lanes;
    // the match lands on the final request of the region.
    load_registers('1, '1, '1, '1, 64'd31);
    repeat (15) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Region shorter than the signature ends unmatched.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Length code zero behaves as one.
    load_registers('1, '1, '1, '1, 64'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Pattern bit outside its mask never matches, even on an exact byte.
    load_registers(64'h1F, 64'd0, 64'h0F, 64'd0, 64'd1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h1F, 1'b1);

    // Three idling regimes: slow receiver, slow sender, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : ((phase == 1) ? 62 : 0);
      recv_idle_pct = (phase == 0) ? 62 : ((phase == 1) ? 6 : 0);
      phase_goal    = scoreboard.requests_noted + 400;
      while (scoreboard.requests_noted < phase_goal) begin
        apply_random_signature();
        for (int r = 0; r < 6 && scoreboard.requests_noted < phase_goal; r++) play_region();
      end
    end

    // Drain, then allow the pipe to show any stray result.
    settle_block();
    repeat (4) @(posedge clk);
    if (scoreboard.error_count == 0) begin
      $display("masked_byte_signature_scan test passed");
    end else begin
      $display("masked_byte_signature_scan test failed");
    end
    $finish;
  end

endmodule
